FILE: rtl/ipv4_tcp_udp_checksum_fixer_top_macros.svh
// ============================================================================
// IPv4 TCP/UDP checksum block - assertion macros
// Shared concurrent assertion forms used by the top level.
// ============================================================================
`ifndef IPV4_TCP_UDP_CHECKSUM_FIXER_TOP_MACROS_SVH
`define IPV4_TCP_UDP_CHECKSUM_FIXER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define IPCSUM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ipcsum assertion failed");

// next-cycle implication, disabled in reset
`define IPCSUM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ipcsum assertion failed");

`endif

FILE: rtl/ipcsum_pkg.sv
// ============================================================================
// IPv4 TCP/UDP checksum package
// Shared types, constants and the one's-complement add.
// ============================================================================
`default_nettype none

package ipcsum_pkg;

    localparam int MAX_FRAME_BYTES = 16384;

    localparam int ETH_HDR_BYTES = 14;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [2:0] ST_NOT_IP  = 3'd0;
    localparam logic [2:0] ST_OTHER   = 3'd1;
    localparam logic [2:0] ST_UDP     = 3'd2;
    localparam logic [2:0] ST_TCP     = 3'd3;
    localparam logic [2:0] ST_VERSION = 3'd4;
    localparam logic [2:0] ST_TRUNC   = 3'd5;
    localparam logic [2:0] ST_BAD_LEN = 3'd6;

    typedef struct packed {
        logic       valid;
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] checksum;
        logic [13:0] field_offset;
        logic [14:0] frame_length;
    } t_result;

    // one's-complement add with end-around carry
    function automatic logic [15:0] csum_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? (s[15:0] + 16'd1) : s[15:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ipcsum_in_stage.sv
// ============================================================================
// IPv4 TCP/UDP checksum - input register
// Holds one accepted frame byte until the core consumes it.
// ============================================================================
`default_nettype none

module ipcsum_in_stage (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [7:0]           i_frame_byte,
    input  wire logic                 i_frame_end,
    input  wire logic                 i_advance,
    output      logic                 o_ready,
    output      ipcsum_pkg::t_in_req  o_req
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_frame_byte;
            r_end  <= i_frame_end;
        end
    end

    assign o_req.valid      = r_valid;
    assign o_req.frame_byte = r_byte;
    assign o_req.frame_end  = r_end;

endmodule

`default_nettype wire

FILE: rtl/ipcsum_core.sv
// ============================================================================
// IPv4 TCP/UDP checksum - parse and sum core
// Tracks header fields, accumulates the checksum and builds the result.
// ============================================================================
`default_nettype none

module ipcsum_core #(
    parameter int MAX_FRAME_BYTES = ipcsum_pkg::MAX_FRAME_BYTES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ipcsum_pkg::t_in_req  i_req,
    input  wire logic                 i_out_free,
    output      logic                 o_advance,
    output      logic                 o_load,
    output      ipcsum_pkg::t_result  o_result
);

    localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CW    = (IDX_W > 17) ? IDX_W : 17;

    logic [IDX_W-1:0] r_idx,   n_idx;
    logic [15:0]      r_sum,   n_sum;
    logic             r_ether, n_ether;
    logic [3:0]       r_ver,   n_ver;
    logic [3:0]       r_hw,    n_hw;
    logic [15:0]      r_total, n_total;
    logic [7:0]       r_proto, n_proto;
    logic             r_ovf,   n_ovf;
    logic [15:0]      r_pseudo, n_pseudo;

    logic          fire;
    logic [7:0]    b;
    logic [CW-1:0] idx_c;
    logic          in_range;
    logic [CW-1:0] seg_start, seg_end, fo;
    logic          proto_ok;
    logic          counts;
    logic [15:0]   contrib;

    logic [CW-1:0] n_c;
    logic [15:0]   hlen;
    logic [15:0]   seg_len;
    logic [4:0]    rel;
    logic          n_udp, n_tcp;
    logic          bad_len;
    logic [15:0]   fin_sum, ck;

    assign b         = i_req.frame_byte;
    assign o_advance = !i_req.frame_end || i_out_free;
    assign fire      = i_req.valid && o_advance;
    assign o_load    = fire && i_req.frame_end;

    assign idx_c     = CW'(r_idx);
    assign in_range  = idx_c < CW'(MAX_FRAME_BYTES);
    assign seg_start = CW'(ipcsum_pkg::ETH_HDR_BYTES) + CW'({r_hw, 2'b00});
    assign seg_end   = CW'(ipcsum_pkg::ETH_HDR_BYTES) + CW'(r_total);
    assign proto_ok  = (r_proto == ipcsum_pkg::PROTO_TCP) || (r_proto == ipcsum_pkg::PROTO_UDP);
    assign fo        = seg_start + ((r_proto == ipcsum_pkg::PROTO_UDP) ? CW'(6) : CW'(16));
    assign contrib   = r_idx[0] ? {8'h00, b} : {b, 8'h00};

    always_comb begin
        counts = (idx_c >= CW'(26)) && (idx_c < CW'(34));
        if ((idx_c >= CW'(18)) && (idx_c >= seg_start) && (idx_c < seg_end)) begin
            counts = 1'b1;
            if ((idx_c >= CW'(24)) && proto_ok && ((idx_c == fo) || (idx_c == fo + CW'(1)))) begin
                counts = 1'b0;
            end
        end
    end

    always_comb begin
        n_idx   = r_idx;
        n_sum   = r_sum;
        n_ether = r_ether;
        n_ver   = r_ver;
        n_hw    = r_hw;
        n_total = r_total;
        n_proto = r_proto;
        n_ovf   = r_ovf;
        if (in_range) begin
            n_idx = r_idx + IDX_W'(1);
            if (idx_c == CW'(12)) begin
                n_ether = (b == 8'h08);
            end
            if (idx_c == CW'(13)) begin
                n_ether = r_ether && (b == 8'h00);
            end
            if (idx_c == CW'(14)) begin
                n_ver = b[7:4];
                n_hw  = b[3:0];
            end
            if (idx_c == CW'(16)) begin
                n_total = {b, r_total[7:0]};
            end
            if (idx_c == CW'(17)) begin
                n_total = {r_total[15:8], b};
            end
            if (idx_c == CW'(23)) begin
                n_proto = b;
            end
            if (counts) begin
                n_sum = ipcsum_pkg::csum_add(r_sum, contrib);
            end
        end else begin
            n_ovf = 1'b1;
        end
    end

    // pseudo-header part; header fields are settled long before any checksummed frame ends
    assign n_pseudo = ipcsum_pkg::csum_add({8'h00, r_proto}, r_total - {10'd0, r_hw, 2'b00});

    assign n_c     = CW'(n_idx);
    assign hlen    = {10'd0, n_hw, 2'b00};
    assign seg_len = n_total - hlen;
    assign n_udp   = (n_proto == ipcsum_pkg::PROTO_UDP);
    assign n_tcp   = (n_proto == ipcsum_pkg::PROTO_TCP);
    assign rel     = n_udp ? 5'd6 : 5'd16;
    assign bad_len = (n_hw < 4'd5) || (n_total < hlen) ||
                     (seg_len < 16'(rel + 5'd2)) || n_ovf;
    assign fin_sum = ipcsum_pkg::csum_add(n_sum, r_pseudo);
    assign ck      = (n_udp && (fin_sum == 16'hFFFF)) ? 16'hFFFF : ~fin_sum;

    always_comb begin
        o_result.status       = ipcsum_pkg::ST_NOT_IP;
        o_result.checksum     = 16'd0;
        o_result.field_offset = 14'd0;
        o_result.frame_length = 15'(n_idx);
        priority if (n_c < CW'(ipcsum_pkg::ETH_HDR_BYTES)) begin
            o_result.status = ipcsum_pkg::ST_TRUNC;
        end else if (!n_ether) begin
            o_result.status = ipcsum_pkg::ST_NOT_IP;
        end else if (n_c < CW'(15)) begin
            o_result.status = ipcsum_pkg::ST_TRUNC;
        end else if (n_ver != 4'd4) begin
            o_result.status = ipcsum_pkg::ST_VERSION;
        end else if (n_c < CW'(24)) begin
            o_result.status = ipcsum_pkg::ST_TRUNC;
        end else if (!n_udp && !n_tcp) begin
            o_result.status = ipcsum_pkg::ST_OTHER;
        end else if (bad_len) begin
            o_result.status = ipcsum_pkg::ST_BAD_LEN;
        end else if (n_c < CW'(ipcsum_pkg::ETH_HDR_BYTES) + CW'(n_total)) begin
            o_result.status = ipcsum_pkg::ST_TRUNC;
        end else begin
            o_result.status       = n_udp ? ipcsum_pkg::ST_UDP : ipcsum_pkg::ST_TCP;
            o_result.checksum     = ck;
            o_result.field_offset = 14'(ipcsum_pkg::ETH_HDR_BYTES) + 14'(hlen) + 14'(rel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_sum    <= '0;
            r_ether  <= 1'b0;
            r_ver    <= '0;
            r_hw     <= '0;
            r_total  <= '0;
            r_proto  <= '0;
            r_ovf    <= 1'b0;
            r_pseudo <= '0;
        end else if (fire) begin
            if (i_req.frame_end) begin
                r_idx    <= '0;
                r_sum    <= '0;
                r_ether  <= 1'b0;
                r_ver    <= '0;
                r_hw     <= '0;
                r_total  <= '0;
                r_proto  <= '0;
                r_ovf    <= 1'b0;
                r_pseudo <= '0;
            end else begin
                r_idx    <= n_idx;
                r_sum    <= n_sum;
                r_ether  <= n_ether;
                r_ver    <= n_ver;
                r_hw     <= n_hw;
                r_total  <= n_total;
                r_proto  <= n_proto;
                r_ovf    <= n_ovf;
                r_pseudo <= n_pseudo;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ipcsum_out_stage.sv
// ============================================================================
// IPv4 TCP/UDP checksum - result register
// Holds one frame result until the receiver takes it.
// ============================================================================
`default_nettype none

module ipcsum_out_stage (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire ipcsum_pkg::t_result  i_result,
    input  wire logic                 i_ready,
    output      logic                 o_valid,
    output      logic                 o_free,
    output      ipcsum_pkg::t_result  o_result
);

    logic                r_valid;
    ipcsum_pkg::t_result r_result;

    assign o_valid  = r_valid;
    assign o_free   = !r_valid || i_ready;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ipv4_tcp_udp_checksum_fixer_top.sv
// ============================================================================
// IPv4 TCP/UDP checksum - top level
// Streams Ethernet frame bytes and reports one checksum result per frame.
// ============================================================================
// Input channel: i_in_valid / o_in_ready carry one frame byte per request,
//   with i_frame_end marking the last byte of a frame.
// Output channel: o_out_valid / i_out_ready carry one result per frame:
//   status, checksum, checksum field offset and counted frame length.
// Throughput: one byte per cycle while no final byte waits on the result register,
//   set by the single add with end-around carry per byte in the core.
// Result path: a final byte sits in the input register until the result register
//   is free, then the result register loads and the result becomes valid.
// Stall: while a result waits in the output register, non-final bytes keep
//   flowing; a final byte waits in the input register until the result is taken.
// Reset: synchronous, active low; clears both registers' valid flags and all
//   per-frame state, so the next byte accepted is byte 0 of a frame.
// Bytes beyond MAX_FRAME_BYTES in one frame are dropped; in an IPv4 TCP or UDP frame they flag a bad length.
// ============================================================================
`default_nettype none

`include "ipv4_tcp_udp_checksum_fixer_top_macros.svh"

module ipv4_tcp_udp_checksum_fixer_top #(
    parameter int MAX_FRAME_BYTES = ipcsum_pkg::MAX_FRAME_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    input  wire logic [7:0]  i_frame_byte,
    input  wire logic        i_frame_end,
    output      logic        o_out_valid,
    input  wire logic        i_out_ready,
    output      logic [2:0]  o_status,
    output      logic [15:0] o_checksum,
    output      logic [13:0] o_field_offset,
    output      logic [14:0] o_frame_length
);

    ipcsum_pkg::t_in_req w_req;
    ipcsum_pkg::t_result w_result;
    ipcsum_pkg::t_result w_out_result;
    logic                w_advance;
    logic                w_load;
    logic                w_out_free;

    ipcsum_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_frame_byte (i_frame_byte),
        .i_frame_end  (i_frame_end),
        .i_advance    (w_advance),
        .o_ready      (o_in_ready),
        .o_req        (w_req)
    );

    ipcsum_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_out_free (w_out_free),
        .o_advance  (w_advance),
        .o_load     (w_load),
        .o_result   (w_result)
    );

    ipcsum_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_result (w_result),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_free   (w_out_free),
        .o_result (w_out_result)
    );

    assign o_status       = w_out_result.status;
    assign o_checksum     = w_out_result.checksum;
    assign o_field_offset = w_out_result.field_offset;
    assign o_frame_length = w_out_result.frame_length;

    `IPCSUM_ASSERT_IMPLY(a_no_csum_unless_l4, i_clk, i_rst_n,
        o_out_valid && (o_status != ipcsum_pkg::ST_UDP) && (o_status != ipcsum_pkg::ST_TCP),
        (o_checksum == 16'd0) && (o_field_offset == 14'd0))

    `IPCSUM_ASSERT_IMPLY(a_udp_csum_nonzero, i_clk, i_rst_n,
        o_out_valid && (o_status == ipcsum_pkg::ST_UDP), o_checksum != 16'd0)

    `IPCSUM_ASSERT_IMPLY(a_offset_past_header, i_clk, i_rst_n,
        o_out_valid && ((o_status == ipcsum_pkg::ST_UDP) || (o_status == ipcsum_pkg::ST_TCP)),
        o_field_offset >= 14'd40)

    `IPCSUM_ASSERT_NEXT(a_load_lands, i_clk, i_rst_n,
        w_load, o_out_valid && (o_status == $past(w_result.status)))

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// IPv4 TCP/UDP checksum testbench
// Streams Ethernet frames into the checksum block byte by byte and checks each
// per-frame result (status, checksum, field offset, frame length) against an
// in-bench predictor, under random gaps and output back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int          CLK_HALF_NS    = 4;
    localparam int          RESET_CYCLES   = 9;
    localparam int          CYCLE_LIMIT    = 600000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          RX_HOLD_CYCLES = 400;
    localparam int          RANDOM_BYTES   = 360;
    localparam int          RANDOM_FRAMES  = 6;
    localparam int          IDLE_PCT       = 26;
    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;

    localparam int OFS_ETYPE_HI = 12;
    localparam int OFS_ETYPE_LO = 13;
    localparam int OFS_VER_IHL  = 14;
    localparam int OFS_TLEN_HI  = 16;
    localparam int OFS_TLEN_LO  = 17;
    localparam int OFS_FIRST_SEG = 18;
    localparam int OFS_PROTO    = 23;
    localparam int OFS_PROTO_NEXT = 24;
    localparam int OFS_ADDR_LO  = 26;
    localparam int OFS_ADDR_HI  = 34;

    typedef logic [7:0] t_frame[$];

    typedef struct packed {
        logic [14:0] idx;
        logic [15:0] sum;
        logic        is_ip;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [15:0] tot_len;
        logic [7:0]  proto;
        logic        ovf;
    } t_csum_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_frame_byte = 8'h00;
    logic        i_frame_end = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_status;
    logic [15:0] o_checksum;
    logic [13:0] o_field_offset;
    logic [14:0] o_frame_length;

    t_csum_state         model_st = '0;
    ipcsum_pkg::t_result pending_results[$];
    int          err_cnt = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    int          results_seen = 0;
    int          status_hits[7];
    int          cycle_cnt = 0;
    int          hold_cnt = 0;
    logic        hold_req = 1'b0;
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;

    ipv4_tcp_udp_checksum_fixer_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_frame_byte   (i_frame_byte),
        .i_frame_end    (i_frame_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_checksum     (o_checksum),
        .o_field_offset (o_field_offset),
        .o_frame_length (o_frame_length)
    );

    initial begin
        forever begin
            #CLK_HALF_NS i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_cnt);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? (s[15:0] + 16'd1) : s[15:0];
    endfunction

    // advances the per-frame state by one byte; returns 1 with the result on frame end
    function automatic bit csum_frame_step(inout t_csum_state st, input logic [7:0] b,
                                           input logic last,
                                           output ipcsum_pkg::t_result r);
        int pos, seg_start, seg_end, fo, n, hlen, rel, tot;
        bit counts;
        bit l4;
        logic [15:0] s, c;
        r = '0;
        if (st.idx < ipcsum_pkg::MAX_FRAME_BYTES) begin
            pos = st.idx;
            seg_start = ipcsum_pkg::ETH_HDR_BYTES + 4 * st.ihl;
            seg_end = ipcsum_pkg::ETH_HDR_BYTES + st.tot_len;
            counts = 1'b0;
            case (pos)
                OFS_ETYPE_HI: st.is_ip = (b == ETYPE_IPV4[15:8]);
                OFS_ETYPE_LO: st.is_ip = st.is_ip && (b == ETYPE_IPV4[7:0]);
                OFS_VER_IHL: begin
                    st.ver = b[7:4];
                    st.ihl = b[3:0];
                end
                OFS_TLEN_HI: st.tot_len[15:8] = b;
                OFS_TLEN_LO: st.tot_len[7:0] = b;
                OFS_PROTO: st.proto = b;
                default: ;
            endcase
            if (pos >= OFS_ADDR_LO && pos < OFS_ADDR_HI) counts = 1'b1;
            if (pos >= OFS_FIRST_SEG && pos >= seg_start && pos < seg_end) begin
                counts = 1'b1;
                l4 = (st.proto == ipcsum_pkg::PROTO_TCP) || (st.proto == ipcsum_pkg::PROTO_UDP);
                if (pos >= OFS_PROTO_NEXT && l4) begin
                    fo = seg_start + ((st.proto == ipcsum_pkg::PROTO_UDP) ? 6 : 16);
                    if (pos == fo || pos == fo + 1) counts = 1'b0;
                end
            end
            if (counts) st.sum = ones_add(st.sum, pos[0] ? {8'h00, b} : {b, 8'h00});
            st.idx = st.idx + 15'd1;
        end else begin
            st.ovf = 1'b1;
        end
        if (!last) return 1'b0;

        n = st.idx;
        hlen = 4 * st.ihl;
        tot = st.tot_len;
        rel = (st.proto == ipcsum_pkg::PROTO_UDP) ? 6 : 16;
        if (n < ipcsum_pkg::ETH_HDR_BYTES) begin
            r.status = ipcsum_pkg::ST_TRUNC;
        end else if (!st.is_ip) begin
            r.status = ipcsum_pkg::ST_NOT_IP;
        end else if (n < OFS_VER_IHL + 1) begin
            r.status = ipcsum_pkg::ST_TRUNC;
        end else if (st.ver != 4'd4) begin
            r.status = ipcsum_pkg::ST_VERSION;
        end else if (n < OFS_PROTO_NEXT) begin
            r.status = ipcsum_pkg::ST_TRUNC;
        end else if (st.proto != ipcsum_pkg::PROTO_TCP && st.proto != ipcsum_pkg::PROTO_UDP) begin
            r.status = ipcsum_pkg::ST_OTHER;
        end else if (st.ihl < 4'd5 || tot < hlen || tot - hlen < rel + 2 || st.ovf) begin
            r.status = ipcsum_pkg::ST_BAD_LEN;
        end else if (n < ipcsum_pkg::ETH_HDR_BYTES + tot) begin
            r.status = ipcsum_pkg::ST_TRUNC;
        end else begin
            s = ones_add(st.sum, {8'h00, st.proto});
            s = ones_add(s, 16'(tot - hlen));
            c = ~s;
            if (st.proto == ipcsum_pkg::PROTO_UDP && c == 16'h0000) c = 16'hFFFF;
            r.checksum = c;
            r.field_offset = 14'(ipcsum_pkg::ETH_HDR_BYTES + hlen + rel);
            r.status = (st.proto == ipcsum_pkg::PROTO_UDP) ? ipcsum_pkg::ST_UDP
                                                           : ipcsum_pkg::ST_TCP;
        end
        r.frame_length = 15'(n);
        st = '0;
        return 1'b1;
    endfunction

    // fill < 0 gives random segment bytes, otherwise every segment byte is fill
    function automatic t_frame make_ip_frame(input logic [15:0] etype, input logic [3:0] ver,
                                             input logic [3:0] ihl, input logic [7:0] proto,
                                             input int seg_len, input int pad, input int fill);
        t_frame f;
        logic [15:0] tot;
        tot = 16'(4 * ihl + seg_len);
        repeat (12) f.push_back(8'($urandom));
        f.push_back(etype[15:8]);
        f.push_back(etype[7:0]);
        f.push_back({ver, ihl});
        f.push_back(8'($urandom));
        f.push_back(tot[15:8]);
        f.push_back(tot[7:0]);
        repeat (5) f.push_back(8'($urandom));
        f.push_back(proto);
        repeat (10) f.push_back(8'($urandom));
        if (ihl > 4'd5) repeat (4 * ihl - 20) f.push_back(8'($urandom));
        repeat (seg_len) f.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        repeat (pad) f.push_back(8'($urandom));
        return f;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t MISMATCH %s: expected 0x%0h actual 0x%0h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        ipcsum_pkg::t_result r;
        if (tx_idle_en) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_frame_byte <= b;
        i_frame_end <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
        if (csum_frame_step(model_st, b, last, r)) pending_results.push_back(r);
    endtask

    task automatic send_frame(input t_frame f);
        foreach (f[k]) send_byte(f[k], k == f.size() - 1);
        frames_sent++;
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (hold_req) hold_cnt <= RX_HOLD_CYCLES;
        else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    end

    always @(posedge i_clk) begin
        if (hold_req || hold_cnt != 0) i_out_ready <= 1'b0;
        else if (rx_idle_en) i_out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        else i_out_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        ipcsum_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t MISMATCH unexpected result: status %0d checksum 0x%0h len %0d",
                         $time, o_status, o_checksum, o_frame_length);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("checksum", want.checksum, o_checksum);
                check_field("field_offset", want.field_offset, o_field_offset);
                check_field("frame_length", want.frame_length, o_frame_length);
            end
            results_seen++;
            if (o_status <= ipcsum_pkg::ST_BAD_LEN) status_hits[o_status]++;
        end
    end

    task automatic test_directed();
        t_frame f;
        t_csum_state st;
        ipcsum_pkg::t_result r;
        send_frame(make_ip_frame(ETYPE_IPV4, 4'd4, 4'd5, ipcsum_pkg::PROTO_UDP, 16, 0, -1));
        send_frame(make_ip_frame(ETYPE_IPV4, 4'd4, 4'd5, ipcsum_pkg::PROTO_TCP, 24, 0, -1));
        send_frame(make_ip_frame(ETYPE_IPV4, 4'd4, 4'd15, ipcsum_pkg::PROTO_TCP, 20, 3, 8'hFF));
        send_frame(make_ip_frame(ETYPE_IPV4, 4'd4, 4'd5, ipcsum_pkg::PROTO_UDP, 8, 6, 8'h00));

        // UDP payload word chosen so the sum is all ones: reported as 0xFFFF
        f = make_ip_frame(ETYPE_IPV4, 4'd4, 4'd5, ipcsum_pkg::PROTO_UDP, 12, 0, -1);
        f[42] = 8'h00;
        f[43] = 8'h00;
        st = '0;
        foreach (f[k]) void'(csum_frame_step(st, f[k], k == f.size() - 1, r));
        f[42] = r.checksum[15:8];
        f[43] = r.checksum[7:0];
        send_frame(f);

        send_frame(make_ip_frame(16'h86DD, 4'd4, 4'd5, ipcsum_pkg::PROTO_UDP, 16, 0, -1));
        send_frame(make_ip_frame(16'h0801, 4'd4, 4'd5, ipcsum_pkg::PROTO_TCP, 20, 0, -1));
        send_frame(make_ip_frame(ETYPE_IPV4, 4'd4, 4'd5, 8'd1, 16, 0, -1));
        send_frame(make_ip_frame(ETYPE_IPV4, 4'd4, 4'd5, 8'hFF, 16, 0, -1));
        send_frame(make_ip_frame(ETYPE_IPV4, 4'd6, 4'd5, ipcsum_pkg::PROTO_UDP, 16, 0, -1));
        send_frame(make_ip_frame(ETYPE_IPV4, 4'd15, 4'd5, ipcsum_pkg::PROTO_TCP, 20, 0, -1));

        f = {8'hFF};
        send_frame(f);
        f = {8'h00};
        send_frame(f);
        f = make_ip_frame(ETYPE_IPV4, 4'd4, 4'd5, ipcsum_pkg::PROTO_UDP, 16, 0, -1);
        repeat (f.size() - 13) void'(f.pop_back());
        send_frame(f);
        f = make_ip_frame(ETYPE_IPV4, 4'd4, 4'd5, ipcsum_pkg::PROTO_UDP, 16, 0, -1);
        repeat (f.size() - 14) void'(f.pop_back());
        send_frame(f);
        f = make_ip_frame(ETYPE_IPV4, 4'd4, 4'd5, ipcsum_pkg::PROTO_UDP, 16, 0, -1);
        repeat (f.size() - 20) void'(f.pop_back());
        send_frame(f);

        send_frame(make_ip_frame(ETYPE_IPV4, 4'd4, 4'd4, ipcsum_pkg::PROTO_UDP, 16, 0, -1));
        f = make_ip_frame(ETYPE_IPV4, 4'd4, 4'd5, ipcsum_pkg::PROTO_TCP, 24, 0, -1);
        f[OFS_TLEN_HI] = 8'h00;
        f[OFS_TLEN_LO] = 8'd10;
        send_frame(f);
        send_frame(make_ip_frame(ETYPE_IPV4, 4'd4, 4'd5, ipcsum_pkg::PROTO_UDP, 7, 0, -1));
        send_frame(make_ip_frame(ETYPE_IPV4, 4'd4, 4'd5, ipcsum_pkg::PROTO_TCP, 17, 0, -1));
        f = make_ip_frame(ETYPE_IPV4, 4'd4, 4'd5, ipcsum_pkg::PROTO_UDP, 20, 0, -1);
        repeat (5) void'(f.pop_back());
        send_frame(f);
        f = make_ip_frame(ETYPE_IPV4, 4'd4, 4'd5, ipcsum_pkg::PROTO_TCP, 24, 0, -1);
        f[OFS_TLEN_HI] = 8'hFF;
        f[OFS_TLEN_LO] = 8'hFF;
        send_frame(f);
        wait_results_drained();
    endtask

    task automatic test_backpressure();
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        repeat (3) begin
            send_frame(make_ip_frame(ETYPE_IPV4, 4'd4, 4'd5, ipcsum_pkg::PROTO_UDP, 8, 0, -1));
            send_frame(make_ip_frame(ETYPE_IPV4, 4'd4, 4'd5, ipcsum_pkg::PROTO_TCP, 18, 1, -1));
        end
        wait_results_drained();
    endtask

    task automatic test_random();
        t_frame f;
        int byte_start, n_frames, kind, cut;
        logic [7:0] proto;
        logic [3:0] ihl;
        byte_start = bytes_sent;
        n_frames = 0;
        while (bytes_sent - byte_start < RANDOM_BYTES || n_frames < RANDOM_FRAMES) begin
            tx_idle_en = !(n_frames >= 1 && n_frames < 5);
            rx_idle_en = tx_idle_en;
            kind = $urandom_range(0, 99);
            proto = $urandom_range(0, 1) ? ipcsum_pkg::PROTO_UDP : ipcsum_pkg::PROTO_TCP;
            ihl = ($urandom_range(0, 99) < 80) ? 4'd5 : 4'($urandom_range(6, 15));
            if (kind < 75) begin
                f = make_ip_frame(ETYPE_IPV4, 4'd4, ihl, proto,
                                  ((proto == ipcsum_pkg::PROTO_UDP) ? 8 : 18) +
                                  $urandom_range(0, 24),
                                  ($urandom_range(0, 99) < 30) ? $urandom_range(1, 8) : 0, -1);
                if (kind >= 65) begin
                    cut = $urandom_range(1, f.size() - 1);
                    repeat (f.size() - cut) void'(f.pop_back());
                end
            end else if (kind < 88) begin
                if ($urandom_range(0, 2) == 0) proto = 8'($urandom);
                f = make_ip_frame(($urandom_range(0, 3) == 0) ? 16'($urandom) : ETYPE_IPV4,
                                  ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd4,
                                  4'($urandom), proto, $urandom_range(0, 30),
                                  $urandom_range(0, 4), -1);
                if ($urandom_range(0, 1)) begin
                    f[OFS_TLEN_HI] = ($urandom_range(0, 1)) ? 8'($urandom) : 8'h00;
                    f[OFS_TLEN_LO] = 8'($urandom);
                end
            end else begin
                f = {};
                repeat ($urandom_range(1, 40)) f.push_back(8'($urandom));
                if (f.size() > 13 && $urandom_range(0, 1)) begin
                    f[OFS_ETYPE_HI] = ETYPE_IPV4[15:8];
                    f[OFS_ETYPE_LO] = ETYPE_IPV4[7:0];
                end
                if (f.size() > 14 && $urandom_range(0, 1)) f[OFS_VER_IHL] = 8'h45;
            end
            send_frame(f);
            n_frames++;
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        wait_results_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random();

        $display("Sent %0d frames (%0d bytes), checked %0d results, %0d errors",
                 frames_sent, bytes_sent, results_seen, err_cnt);
        $display("Status mix: not-ip %0d other %0d udp %0d tcp %0d",
                 status_hits[ipcsum_pkg::ST_NOT_IP], status_hits[ipcsum_pkg::ST_OTHER],
                 status_hits[ipcsum_pkg::ST_UDP], status_hits[ipcsum_pkg::ST_TCP]);
        $display("            version %0d trunc %0d badlen %0d",
                 status_hits[ipcsum_pkg::ST_VERSION], status_hits[ipcsum_pkg::ST_TRUNC],
                 status_hits[ipcsum_pkg::ST_BAD_LEN]);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
